// ===== design/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
// Used by the front end, the work queue, the line engine and the top level.
// No dependencies.
package i2cm_pkg;

    // Default width of the shift register (data bits per transfer).
    localparam int DATA_BITS_DEF = 8;

    // Width of a configuration register and of the index on the write port.
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SS_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE   = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [CFG_W-1:0] SS_HOLD_RST     = 8'd4;
    localparam logic [CFG_W-1:0] BIT_PHASE_RST   = 8'd2;

    // Command codes.
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_WACK  = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Input word: one time tick with the sampled line and an optional command.
    typedef struct packed {
        logic       tick;
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // Result word: line levels and status after the tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_en;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } result_t;

    // Classified word handed from the front end to the engine.
    typedef struct packed {
        logic       tick;
        logic       cmd_ok;
        op_t        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } work_t;

    // Configuration seen by the engine.
    typedef struct packed {
        logic [CFG_W-1:0] ack_timeout_limit;
        logic [CFG_W-1:0] start_stop_hold;
        logic [CFG_W-1:0] bit_phase_ticks;
    } cfg_t;

endpackage

// ===== design/i2cm_front.sv =====
// Front end of the I2C master bit engine: classifies each input word.
// Depends on i2cm_pkg.
module i2cm_front
    import i2cm_pkg::*;
(
    input  item_t item,
    output work_t work
);

    // Decode the command; unknown operation codes are marked as no command.
    always_comb
    begin
        work.tick     = item.tick;
        work.tx_byte  = item.tx_byte;
        work.send_ack = item.send_ack;
        work.sda_in   = item.sda_in;
        work.op       = OP_START;
        work.cmd_ok   = 1'b0;
        unique case (item.operation)
            OP_START, OP_STOP, OP_WRITE, OP_WACK, OP_READ:
            begin
                work.op     = op_t'(item.operation);
                work.cmd_ok = item.cmd_valid;
            end
            default:
            begin
                work.cmd_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/i2cm_queue.sv =====
// Two-entry queue of classified words between the front end and the engine.
// Depends on i2cm_pkg.
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output work_t pop_data
);

    work_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_next;
    logic [1:0]  count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage of the words themselves; no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/i2cm_engine.sv =====
// Back end of the I2C master bit engine: phase sequencer, line registers and
// the result register. Depends on i2cm_pkg.
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    work_valid,
    input  work_t   work,
    output logic    work_pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_WR_SETUP,
        PH_WR_HIGH,
        PH_WR_LOW,
        PH_WA_REL,
        PH_WA_HIGH,
        PH_WA_POLL,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_AK_LOW,
        PH_AK_HIGH
    } phase_t;

    phase_t               phase_reg,       phase_next;
    logic [7:0]           phase_ticks_reg, phase_ticks_next;
    logic [IDX_W-1:0]     bit_index_reg,   bit_index_next;
    logic [DATA_BITS-1:0] shift_reg_reg,   shift_reg_next;
    logic [7:0]           wait_count_reg,  wait_count_next;
    logic                 scl_reg,         scl_next;
    logic                 sda_reg,         sda_next;
    logic                 en_reg,          en_next;
    logic                 ack_mode_reg,    ack_mode_next;
    logic [7:0]           rx_reg,          rx_next;
    logic                 fail_reg,        fail_next;
    logic                 res_valid_reg,   res_valid_next;
    result_t              res_reg,         res_next;

    logic                 done;
    logic [7:0]           ticks_inc;
    logic [7:0]           hold_raw;
    logic [7:0]           hold;
    logic [DATA_BITS-1:0] shifted;

    // A word leaves the queue whenever the result register is free or drains.
    assign work_pop     = work_valid && (!res_valid_reg || result_ready);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Phase length: start and stop phases use their own hold; zero counts as one.
    always_comb
    begin
        if (phase_reg == PH_ST_A || phase_reg == PH_ST_B ||
            phase_reg == PH_SP_A || phase_reg == PH_SP_B)
        begin
            hold_raw = cfg.start_stop_hold;
        end
        else
        begin
            hold_raw = cfg.bit_phase_ticks;
        end
        hold      = (hold_raw == 8'd0) ? 8'd1 : hold_raw;
        ticks_inc = phase_ticks_reg + 8'd1;
        shifted   = shift_reg_reg << 1;
    end

    // Next state of the sequencer for the word taken this cycle.
    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        bit_index_next   = bit_index_reg;
        shift_reg_next   = shift_reg_reg;
        wait_count_next  = wait_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        en_next          = en_reg;
        ack_mode_next    = ack_mode_reg;
        rx_next          = rx_reg;
        fail_next        = fail_reg;
        done             = 1'b0;

        if (work_pop)
        begin
            if (phase_reg == PH_IDLE)
            begin
                // Start a new command.
                if (work.cmd_ok)
                begin
                    phase_ticks_next = 8'd0;
                    unique case (work.op)
                        OP_START:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            en_next    = 1'b1;
                            phase_next = PH_ST_A;
                        end
                        OP_STOP:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            en_next    = 1'b1;
                            phase_next = PH_SP_A;
                        end
                        OP_WRITE:
                        begin
                            bit_index_next = '0;
                            shift_reg_next = DATA_BITS'(work.tx_byte) << (DATA_BITS - 8);
                            scl_next       = 1'b0;
                            sda_next       = work.tx_byte[7];
                            en_next        = 1'b1;
                            phase_next     = PH_WR_SETUP;
                        end
                        OP_WACK:
                        begin
                            fail_next       = 1'b0;
                            wait_count_next = 8'd0;
                            sda_next        = 1'b1;
                            en_next         = 1'b0;
                            phase_next      = PH_WA_REL;
                        end
                        OP_READ:
                        begin
                            ack_mode_next  = work.send_ack;
                            bit_index_next = '0;
                            shift_reg_next = '0;
                            scl_next       = 1'b0;
                            sda_next       = 1'b1;
                            en_next        = 1'b0;
                            phase_next     = PH_RD_LOW;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            else if (work.tick)
            begin
                if (phase_reg == PH_WA_POLL)
                begin
                    // Poll SDA for the acknowledge once per tick.
                    if (!work.sda_in)
                    begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                    else if (wait_count_reg >= cfg.ack_timeout_limit)
                    begin
                        fail_next        = 1'b1;
                        scl_next         = 1'b0;
                        sda_next         = 1'b0;
                        en_next          = 1'b1;
                        phase_next       = PH_SP_A;
                        phase_ticks_next = 8'd0;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg + 8'd1;
                    end
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                    if (ticks_inc >= hold)
                    begin
                        // The phase has run its length: move the lines on.
                        phase_ticks_next = 8'd0;
                        unique case (phase_reg)
                            PH_ST_A:
                            begin
                                sda_next   = 1'b0;
                                phase_next = PH_ST_B;
                            end
                            PH_ST_B:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            PH_SP_A:
                            begin
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                en_next    = 1'b1;
                                phase_next = PH_SP_B;
                            end
                            PH_WR_SETUP:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_WR_HIGH;
                            end
                            PH_WR_HIGH:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_WR_LOW;
                            end
                            PH_WR_LOW:
                            begin
                                if (bit_index_reg == LAST_IDX)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    bit_index_next = bit_index_reg + 1'b1;
                                    shift_reg_next = shifted;
                                    sda_next       = shifted[DATA_BITS-1];
                                    phase_next     = PH_WR_SETUP;
                                end
                            end
                            PH_WA_REL:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_WA_HIGH;
                            end
                            PH_WA_HIGH:
                            begin
                                phase_next = PH_WA_POLL;
                            end
                            PH_RD_LOW:
                            begin
                                scl_next       = 1'b1;
                                shift_reg_next = {shift_reg_reg[DATA_BITS-2:0], work.sda_in};
                                phase_next     = PH_RD_HIGH;
                            end
                            PH_RD_HIGH:
                            begin
                                if (bit_index_reg == LAST_IDX)
                                begin
                                    rx_next    = shift_reg_reg[7:0];
                                    scl_next   = 1'b0;
                                    sda_next   = ~ack_mode_reg;
                                    en_next    = 1'b1;
                                    phase_next = PH_AK_LOW;
                                end
                                else
                                begin
                                    bit_index_next = bit_index_reg + 1'b1;
                                    scl_next       = 1'b0;
                                    phase_next     = PH_RD_LOW;
                                end
                            end
                            PH_AK_LOW:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_AK_HIGH;
                            end
                            PH_AK_HIGH:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            default:
                            begin
                                // Stop end, and any phase without a sequel.
                                done = 1'b1;
                            end
                        endcase
                    end
                end
                if (done)
                begin
                    phase_next       = PH_IDLE;
                    phase_ticks_next = 8'd0;
                end
            end
        end
    end

    // Result word built from the state after this tick.
    always_comb
    begin
        res_next              = res_reg;
        res_valid_next        = res_valid_reg && !result_ready;
        if (work_pop)
        begin
            res_valid_next        = 1'b1;
            res_next.scl_level    = scl_next;
            res_next.sda_level    = sda_next;
            res_next.sda_drive_en = en_next;
            res_next.busy_res     = (phase_next != PH_IDLE);
            res_next.done_res     = done;
            res_next.rx_byte      = rx_next;
            res_next.ack_failed   = fail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= 8'd0;
            bit_index_reg   <= '0;
            shift_reg_reg   <= '0;
            wait_count_reg  <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            en_reg          <= 1'b1;
            ack_mode_reg    <= 1'b0;
            rx_reg          <= 8'd0;
            fail_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            bit_index_reg   <= bit_index_next;
            shift_reg_reg   <= shift_reg_next;
            wait_count_reg  <= wait_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            en_reg          <= en_next;
            ack_mode_reg    <= ack_mode_next;
            rx_reg          <= rx_next;
            fail_reg        <= fail_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== design/i2c_master_bit_engine.sv =====
// I2C master bit engine. The block takes one input word per clock: each word
// is one time tick with the sampled SDA level and an optional command (start,
// stop, write byte, wait for ACK, read byte with ACK or NACK), and returns one
// result word with the SCL level, SDA level, SDA drive enable and status.
// A word is taken every clock while the two-entry queue has room; the engine
// removes one word per clock whenever its result register is free or being
// read, so the sustained rate is one word per clock while the receiver takes
// every result word. A result word passes through the queue and then the
// result register. Commands offered while a command is running are ignored.
// Configuration registers (ACK timeout, start and stop hold, bit phase
// length) are written through the plain write port.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_engine.
module i2c_master_bit_engine
    import i2cm_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    work_t front_work;
    work_t queue_work;
    logic  queue_not_empty;
    logic  queue_pop;

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ACK_TIMEOUT: cfg_next.ack_timeout_limit = cfg_data;
                REG_SS_HOLD:     cfg_next.start_stop_hold   = cfg_data;
                REG_BIT_PHASE:   cfg_next.bit_phase_ticks   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout_limit <= ACK_TIMEOUT_RST;
            cfg_reg.start_stop_hold   <= SS_HOLD_RST;
            cfg_reg.bit_phase_ticks   <= BIT_PHASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify the incoming word.
    i2cm_front u_front (
        .item (item),
        .work (front_work)
    );

    // Queue between classification and execution.
    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_valid && item_ready),
        .push_data (front_work),
        .not_full  (item_ready),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_work)
    );

    // Line sequencer and result register.
    i2cm_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .work_valid   (queue_not_empty),
        .work         (queue_work),
        .work_pop     (queue_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the I2C master bit engine: directed words, then random
// command sequences under several register settings, checked against a line-level predictor.
// Depends on i2cm_pkg and the i2c_master_bit_engine top level.
module testbench
    import i2cm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes outside the command set; the engine must ignore them.
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    // Line sequencing states of the predictor.
    typedef enum logic [3:0] {
        S_IDLE, S_START_A, S_START_B, S_STOP_A, S_STOP_B,
        S_WR_SETUP, S_WR_HIGH, S_WR_LOW,
        S_ACK_REL, S_ACK_HIGH, S_ACK_POLL,
        S_RD_LOW, S_RD_HIGH, S_MACK_LOW, S_MACK_HIGH
    } line_state_e;

    // One row of the directed plan: a register write or a word to send.
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        item_t                word;
        bit                   checked;
        result_t              want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    // Predictor state and its copy of the registers.
    line_state_e st = S_IDLE;
    logic [7:0] st_ticks = '0;
    logic [3:0] bit_no = '0;
    logic [7:0] shifter = '0;
    logic [7:0] polls = '0;
    logic scl_q = 1'b1;
    logic sda_q = 1'b1;
    logic en_q = 1'b1;
    logic ack_to_send = 1'b0;
    logic [7:0] rx_q = '0;
    logic fail_q = 1'b0;
    logic [7:0] ack_limit = ACK_TIMEOUT_RST;
    logic [7:0] ss_hold = SS_HOLD_RST;
    logic [7:0] bit_hold = BIT_PHASE_RST;

    result_t line_expect_q[$];
    int mismatches = 0;

    // Receiver stall pattern.
    logic [15:0] stall_mask = 16'hFFFF;
    int stall_left = 0;

    i2c_master_bit_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Advances the predicted line state by one word and returns the line levels.
    function automatic result_t line_step(input item_t w);
        logic fin;
        logic [7:0] hold;
        fin = 1'b0;
        if (st == S_IDLE)
        begin
            if (w.cmd_valid && w.operation <= OP_READ)
            begin
                case (w.operation)
                    OP_START:
                    begin
                        {scl_q, sda_q, en_q} = 3'b111;
                        st = S_START_A;
                    end
                    OP_STOP:
                    begin
                        {scl_q, sda_q, en_q} = 3'b001;
                        st = S_STOP_A;
                    end
                    OP_WRITE:
                    begin
                        bit_no = '0;
                        shifter = w.tx_byte;
                        {scl_q, sda_q, en_q} = {1'b0, w.tx_byte[7], 1'b1};
                        st = S_WR_SETUP;
                    end
                    OP_WACK:
                    begin
                        fail_q = 1'b0;
                        polls = '0;
                        {sda_q, en_q} = 2'b10;
                        st = S_ACK_REL;
                    end
                    default:
                    begin
                        ack_to_send = w.send_ack;
                        bit_no = '0;
                        shifter = '0;
                        {scl_q, sda_q, en_q} = 3'b010;
                        st = S_RD_LOW;
                    end
                endcase
                st_ticks = '0;
            end
        end
        else if (w.tick)
        begin
            if (st == S_ACK_POLL)
            begin
                // Poll once per tick; a low SDA is the acknowledge.
                if (!w.sda_in)
                begin
                    scl_q = 1'b0;
                    fin = 1'b1;
                end
                else if (polls >= ack_limit)
                begin
                    fail_q = 1'b1;
                    {scl_q, sda_q, en_q} = 3'b001;
                    st = S_STOP_A;
                    st_ticks = '0;
                end
                else
                begin
                    polls = polls + 8'd1;
                end
            end
            else
            begin
                st_ticks = st_ticks + 8'd1;
                hold = (st >= S_START_A && st <= S_STOP_B) ? ss_hold : bit_hold;
                if (hold == 8'd0) hold = 8'd1;
                if (st_ticks >= hold)
                begin
                    st_ticks = '0;
                    case (st)
                        S_START_A:
                        begin
                            sda_q = 1'b0;
                            st = S_START_B;
                        end
                        S_START_B: {scl_q, fin} = 2'b01;
                        S_STOP_A:
                        begin
                            {scl_q, sda_q, en_q} = 3'b111;
                            st = S_STOP_B;
                        end
                        S_WR_SETUP:
                        begin
                            scl_q = 1'b1;
                            st = S_WR_HIGH;
                        end
                        S_WR_HIGH:
                        begin
                            scl_q = 1'b0;
                            st = S_WR_LOW;
                        end
                        S_WR_LOW:
                        begin
                            if (bit_no >= 4'd7)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                bit_no = bit_no + 4'd1;
                                shifter = {shifter[6:0], 1'b0};
                                sda_q = shifter[7];
                                st = S_WR_SETUP;
                            end
                        end
                        S_ACK_REL:
                        begin
                            scl_q = 1'b1;
                            st = S_ACK_HIGH;
                        end
                        S_ACK_HIGH: st = S_ACK_POLL;
                        S_RD_LOW:
                        begin
                            scl_q = 1'b1;
                            shifter = {shifter[6:0], w.sda_in};
                            st = S_RD_HIGH;
                        end
                        S_RD_HIGH:
                        begin
                            // After the last bit the master drives its own ACK or NACK.
                            if (bit_no >= 4'd7)
                            begin
                                rx_q = shifter;
                                {scl_q, sda_q, en_q} = {1'b0, ~ack_to_send, 1'b1};
                                st = S_MACK_LOW;
                            end
                            else
                            begin
                                bit_no = bit_no + 4'd1;
                                scl_q = 1'b0;
                                st = S_RD_LOW;
                            end
                        end
                        S_MACK_LOW:
                        begin
                            scl_q = 1'b1;
                            st = S_MACK_HIGH;
                        end
                        S_MACK_HIGH: {scl_q, fin} = 2'b01;
                        default: fin = 1'b1;
                    endcase
                end
            end
            if (fin)
            begin
                st = S_IDLE;
                st_ticks = '0;
            end
        end
        return '{scl_q, sda_q, en_q, st != S_IDLE, fin, rx_q, fail_q};
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one word, holds it until taken, then records the expected result.
    task automatic send_word(input item_t w, input bit checked, input result_t want);
        result_t predicted;
        @(negedge clk);
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        predicted = line_step(w);
        line_expect_q.push_back(checked ? want : predicted);
    endtask

    // Writes one register once every outstanding result has come back.
    task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        item_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_ACK_TIMEOUT: ack_limit = val;
            REG_SS_HOLD:     ss_hold = val;
            REG_BIT_PHASE:   bit_hold = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: ready follows a 16-bit mask that is redrawn each time the stall_left countdown reaches zero.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            stall_left <= 48;
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        result_ready <= stall_mask[stall_left[3:0]];
    end

    // Result checker: every word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (line_expect_q.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, got %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = line_expect_q.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(result.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(result.sda_level));
                check_field("sda_drive_en", 8'(want.sda_drive_en), 8'(result.sda_drive_en));
                check_field("busy_res", 8'(want.busy_res), 8'(result.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(result.done_res));
                check_field("rx_byte", want.rx_byte, result.rx_byte);
                check_field("ack_failed", 8'(want.ack_failed), 8'(result.ack_failed));
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t plan[26];
        logic [7:0] lim_plan[6];
        logic [7:0] ss_plan[6];
        logic [7:0] bit_plan[6];
        int phase_len[6];
        logic [2:0] next_op;
        item_t w;
        int burst_left;
        int gap;

        // Directed plan: ignored codes, commands with zero holds, writes ignored mid-command, an ACK
        // timeout, an ACK that clears the failure, and a read left running into the random part.
        plan = '{
            '{1'b0, 2'd0, 8'd0, '{1'b0, 1'b0, OP_START, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_RSVD_LO, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_RSVD_HI, 8'hFF, 1'b1, 1'b1},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{1'b1, REG_SS_HOLD, 8'd0, '0, 1'b0, '0},
            '{1'b1, REG_BIT_PHASE, 8'd0, '0, 1'b0, '0},
            '{1'b1, REG_ACK_TIMEOUT, 8'd0, '0, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_START, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b0, 1'b0, OP_START, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b0, 1'b1, OP_STOP, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_WACK, 8'h00, 1'b0, 1'b1},
              1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1},
              1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1},
              1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_WACK, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b0},
              1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_READ, 8'h00, 1'b1, 1'b0},
              1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
            '{1'b0, 2'd0, 8'd0, '{1'b1, 1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0}, 1'b0, '0}
        };

        // Register settings of the random phases; the last is drawn at random.
        lim_plan = '{ACK_TIMEOUT_RST, 8'd0, 8'd3, 8'd255, 8'd1, 8'd0};
        ss_plan = '{SS_HOLD_RST, 8'd0, 8'd1, 8'd255, 8'd1, 8'd1};
        bit_plan = '{BIT_PHASE_RST, 8'd0, 8'd1, 8'd1, 8'd255, 8'd1};
        phase_len = '{300, 250, 300, 150, 150, 400};
        next_op = OP_START;
        burst_left = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                load_register(plan[i].reg_idx, plan[i].reg_val);
            else
                send_word(plan[i].word, plan[i].checked, plan[i].want);
        end

        // Random part: mostly well-formed transfers, with noise words and broken order.
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                lim_plan[p] = 8'($urandom_range(0, 8));
                ss_plan[p] = 8'($urandom_range(1, 6));
                bit_plan[p] = 8'($urandom_range(1, 4));
            end
            // Every phase boundary holds off the sender until all results are back.
            load_register(REG_ACK_TIMEOUT, lim_plan[p]);
            load_register(REG_SS_HOLD, ss_plan[p]);
            load_register(REG_BIT_PHASE, bit_plan[p]);
            for (int n = 0; n < phase_len[p]; n++)
            begin
                if (burst_left == 0)
                begin
                    gap = $urandom_range(0, 5);
                    if (gap != 0)
                    begin
                        @(negedge clk);
                        item_valid <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                    end
                    burst_left = $urandom_range(1, 48);
                end
                burst_left--;

                w = '0;
                w.tx_byte = 8'($urandom);
                w.send_ack = 1'($urandom);
                w.sda_in = 1'($urandom);
                if (st == S_IDLE && $urandom_range(0, 4) != 0)
                begin
                    w.cmd_valid = 1'b1;
                    w.tick = 1'($urandom);
                    w.operation = ($urandom_range(0, 6) == 0) ? 3'($urandom) : next_op;
                    case (w.operation)
                        OP_START: next_op = OP_WRITE;
                        OP_WRITE: next_op = OP_WACK;
                        OP_WACK:
                        begin
                            gap = $urandom_range(0, 9);
                            next_op = (gap < 4) ? OP_WRITE : (gap < 7) ? OP_READ : OP_STOP;
                        end
                        OP_READ: next_op = ($urandom_range(0, 9) < 4) ? OP_READ : OP_STOP;
                        OP_STOP: next_op = OP_START;
                        default: ;
                    endcase
                end
                else
                begin
                    w.tick = ($urandom_range(0, 9) != 0);
                    w.cmd_valid = ($urandom_range(0, 9) == 0);
                    w.operation = 3'($urandom);
                    if (st == S_ACK_POLL) w.sda_in = ($urandom_range(0, 9) >= 3);
                end
                send_word(w, 1'b0, '0);
            end
        end

        // Drain, then let the pipeline settle before the verdict.
        @(negedge clk);
        item_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && line_expect_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_engine.sv
design/i2c_master_bit_engine.sv
verif/testbench.sv
